// ===== hdl/radix_k_group_neighbor_generator_defines.svh =====
// assertion macros shared by the radix-k group neighbour generator
`ifndef RADIX_K_GROUP_NEIGHBOR_GENERATOR_DEFINES_SVH
`define RADIX_K_GROUP_NEIGHBOR_GENERATOR_DEFINES_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication, sampled on clock, quiet during reset
`define RKG_ASSERT_NOW(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("rkg: same-cycle check failed");
// next-cycle implication, sampled on clock, quiet during reset
`define RKG_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("rkg: next-cycle check failed");
`else
`define RKG_ASSERT_NOW(name, ante, cons)
`define RKG_ASSERT_NEXT(name, ante, cons)
`endif
`endif

// ===== hdl/rkgng_pkg.sv =====
package rkgng_pkg;

   localparam int TASK_BITS     = 32;
   localparam int LEVEL_BITS    = 3;
   localparam int TOTAL_BITS    = 25;
   localparam int RADIX_BITS    = 7;
   localparam int MEMBER_BITS   = 6;
   localparam int ID_BITS       = 27;
   localparam int MUL_BITS      = TOTAL_BITS + RADIX_BITS;
   localparam int DIV_CNT_BITS  = $clog2(TASK_BITS);
   localparam int CSR_IDX_BITS  = 4;
   localparam int CSR_DATA_BITS = 32;
   localparam int RADIX_LIMIT   = 64;

   // register indexes on the csr port
   localparam logic [CSR_IDX_BITS-1:0] CSR_NUM_LEVELS   = 4'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_TOTAL_BLOCKS = 4'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_RADIX_0      = 4'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DECIDE,
      ST_DIV_BLK,
      ST_DIV_QUO,
      ST_DIV_DIG,
      ST_MUL_REST,
      ST_MUL_OFS,
      ST_EMIT,
      ST_ERROR
   } state_type;

endpackage

// ===== hdl/radix_k_group_neighbor_generator.sv =====
// radix-k group neighbour generator
// request channel: start with req_task_base, req_group_level, req_outgoing; a word is
// taken on a clock edge with start high and busy low. busy stays high until the last
// result of that request has been shown.
// result channel: rsp_valid marks each result for exactly one cycle; results of one
// request come in consecutive cycles, member index 0 first, and the final one carries
// rsp_last_member. a bad request gives a single result with rsp_bad_request set.
// csr channel: csr_valid/csr_ready with csr_index and csr_data; csr_ready is always
// high, and registers are only to be changed while busy is low.
// sequence: the radix check walks one level a cycle through a shared 25x7 multiplier,
// then one restoring divider runs three passes (block index, quotient by the prefix
// product, digit), the multiplier states ST_MUL_REST and ST_MUL_OFS form the base
// id, then one result per cycle. a request with num_levels out of range goes straight
// to the bad-request result; any other rejection comes after the radix check.
// reset (synchronous) sets num_levels, total_blocks and every radix to one and
// returns the sequencer to idle. results cannot be held off by the receiver.
`include "radix_k_group_neighbor_generator_defines.svh"

module radix_k_group_neighbor_generator #(
   parameter int MAX_LEVELS       = 6,
   parameter int BLOCK_INDEX_BITS = 24
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  logic [rkgng_pkg::TASK_BITS-1:0]        req_task_base,
   input  logic [rkgng_pkg::LEVEL_BITS-1:0]       req_group_level,
   input  logic                                   req_outgoing,
   output logic                                   rsp_valid,
   output logic [rkgng_pkg::ID_BITS-1:0]          rsp_neighbor_id,
   output logic [rkgng_pkg::MEMBER_BITS-1:0]      rsp_member_index,
   output logic                                   rsp_last_member,
   output logic                                   rsp_bad_request,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [rkgng_pkg::CSR_IDX_BITS-1:0]     csr_index,
   input  logic [rkgng_pkg::CSR_DATA_BITS-1:0]    csr_data
);

   localparam int LVL_BITS = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
   localparam logic [28:0] BLOCK_LIMIT = 29'(1) << BLOCK_INDEX_BITS;

   localparam int TB = rkgng_pkg::TASK_BITS;
   localparam int LB = rkgng_pkg::LEVEL_BITS;
   localparam int NB = rkgng_pkg::TOTAL_BITS;
   localparam int RB = rkgng_pkg::RADIX_BITS;
   localparam int MB = rkgng_pkg::MEMBER_BITS;
   localparam int IB = rkgng_pkg::ID_BITS;
   localparam int PB = rkgng_pkg::MUL_BITS;
   localparam int CB = rkgng_pkg::DIV_CNT_BITS;

   // configuration
   logic [LB-1:0] num_levels_ff, num_levels_in;
   logic [NB-1:0] total_ff, total_in;
   logic [RB-1:0] radix_ff [MAX_LEVELS];
   logic [RB-1:0] radix_in [MAX_LEVELS];

   // sequencer
   rkgng_pkg::state_type state_ff, state_in;
   logic [TB-1:0] base_ff, base_in;
   logic [LB-1:0] lvl_ff, lvl_in;
   logic          dir_ff, dir_in;
   logic [LB-1:0] idx_ff, idx_in;
   logic [NB-1:0] acc_ff, acc_in;
   logic          ovf_ff, ovf_in;
   logic          radix_bad_ff, radix_bad_in;
   logic [NB-1:0] pp_ff, pp_in;
   logic [RB-1:0] r_ff, r_in;
   logic [TB-1:0] num_ff, num_in;
   logic [NB-1:0] rem_ff, rem_in;
   logic [NB-1:0] div_ff, div_in;
   logic [CB-1:0] cnt_ff, cnt_in;
   logic [NB-1:0] blk_ff, blk_in;
   logic [MB-1:0] digit_ff, digit_in;
   logic [NB-1:0] rest_ff, rest_in;
   logic [IB-1:0] id_ff, id_in;
   logic [MB-1:0] member_ff, member_in;

   // shared multiplier and divider step
   logic [NB-1:0] mul_a;
   logic [RB-1:0] mul_b;
   logic [PB-1:0] mul_p;
   logic [NB:0]   rem_shift;
   logic          rem_ge;
   logic [NB-1:0] rem_next;
   logic [TB-1:0] num_next;
   logic          div_done;
   logic [RB-1:0] cur_radix;
   logic [RB-1:0] r_minus_one;
   logic          last_now;
   logic [rkgng_pkg::CSR_IDX_BITS-1:0] csr_slot;
   logic          cfg_ok;

   assign csr_ready = 1'b1;
   assign busy      = (state_ff != rkgng_pkg::ST_IDLE);

   assign cur_radix   = radix_ff[idx_ff[LVL_BITS-1:0]];
   assign mul_p       = {{RB{1'b0}}, mul_a} * {{NB{1'b0}}, mul_b};
   assign rem_shift   = {rem_ff, num_ff[TB-1]};
   assign rem_ge      = (rem_shift >= {1'b0, div_ff});
   assign rem_next    = rem_ge ? NB'(rem_shift - {1'b0, div_ff}) : rem_shift[NB-1:0];
   assign num_next    = {num_ff[TB-2:0], rem_ge};
   assign div_done    = (cnt_ff == CB'(TB - 1));
   assign r_minus_one = r_ff - RB'(1);
   assign last_now    = (member_ff == r_minus_one[MB-1:0]);

   assign cfg_ok = !ovf_ff && !radix_bad_ff && (acc_ff == total_ff)
                   && (total_ff != '0) && ({4'd0, total_ff} <= BLOCK_LIMIT)
                   && (lvl_ff < num_levels_ff);

   always_comb begin
      unique case (state_ff)
         rkgng_pkg::ST_MUL_REST: begin
            mul_a = pp_ff;
            mul_b = {1'b0, digit_ff};
         end
         rkgng_pkg::ST_MUL_OFS: begin
            mul_a = total_ff;
            mul_b = RB'({1'b0, lvl_ff} + {{LB{1'b0}}, dir_ff});
         end
         default: begin
            mul_a = acc_ff;
            mul_b = cur_radix;
         end
      endcase
   end

   // register writes
   assign csr_slot = csr_index - rkgng_pkg::CSR_RADIX_0;

   always_comb begin
      num_levels_in = num_levels_ff;
      total_in      = total_ff;
      for (int i = 0; i < MAX_LEVELS; i++) begin
         radix_in[i] = radix_ff[i];
      end
      if (csr_valid && csr_ready) begin
         if (csr_index == rkgng_pkg::CSR_NUM_LEVELS) begin
            num_levels_in = csr_data[LB-1:0];
         end else if (csr_index == rkgng_pkg::CSR_TOTAL_BLOCKS) begin
            total_in = csr_data[NB-1:0];
         end else if (csr_index >= rkgng_pkg::CSR_RADIX_0) begin
            for (int i = 0; i < MAX_LEVELS; i++) begin
               if (csr_slot == rkgng_pkg::CSR_IDX_BITS'(i)) begin
                  radix_in[i] = csr_data[RB-1:0];
               end
            end
         end
      end
   end

   // sequencer next state and outputs
   always_comb begin
      state_in     = state_ff;
      base_in      = base_ff;
      lvl_in       = lvl_ff;
      dir_in       = dir_ff;
      idx_in       = idx_ff;
      acc_in       = acc_ff;
      ovf_in       = ovf_ff;
      radix_bad_in = radix_bad_ff;
      pp_in        = pp_ff;
      r_in         = r_ff;
      num_in       = num_ff;
      rem_in       = rem_ff;
      div_in       = div_ff;
      cnt_in       = cnt_ff;
      blk_in       = blk_ff;
      digit_in     = digit_ff;
      rest_in      = rest_ff;
      id_in        = id_ff;
      member_in    = member_ff;

      rsp_valid        = 1'b0;
      rsp_neighbor_id  = '0;
      rsp_member_index = '0;
      rsp_last_member  = 1'b0;
      rsp_bad_request  = 1'b0;

      unique case (state_ff)
         rkgng_pkg::ST_IDLE: begin
            if (start) begin
               base_in      = req_task_base;
               lvl_in       = req_group_level;
               dir_in       = req_outgoing;
               idx_in       = '0;
               acc_in       = NB'(1);
               ovf_in       = 1'b0;
               radix_bad_in = 1'b0;
               if (num_levels_ff == '0 || num_levels_ff > LB'(MAX_LEVELS)) begin
                  state_in = rkgng_pkg::ST_ERROR;
               end else begin
                  state_in = rkgng_pkg::ST_CHECK;
               end
            end
         end
         rkgng_pkg::ST_CHECK: begin
            // one level a cycle: running radix product and the chosen level's weight
            if (idx_ff == lvl_ff) begin
               pp_in = acc_ff;
               r_in  = cur_radix;
            end
            if (cur_radix == '0 || cur_radix > RB'(rkgng_pkg::RADIX_LIMIT)) begin
               radix_bad_in = 1'b1;
            end
            acc_in = mul_p[NB-1:0];
            if (mul_p[PB-1:NB] != '0) begin
               ovf_in = 1'b1;
            end
            if (idx_ff == num_levels_ff - LB'(1)) begin
               state_in = rkgng_pkg::ST_DECIDE;
            end else begin
               idx_in = idx_ff + LB'(1);
            end
         end
         rkgng_pkg::ST_DECIDE: begin
            num_in = base_ff;
            rem_in = '0;
            div_in = total_ff;
            cnt_in = '0;
            state_in = cfg_ok ? rkgng_pkg::ST_DIV_BLK : rkgng_pkg::ST_ERROR;
         end
         rkgng_pkg::ST_DIV_BLK: begin
            num_in = num_next;
            rem_in = rem_next;
            cnt_in = cnt_ff + CB'(1);
            if (div_done) begin
               // block index kept, then divided by the level weight
               blk_in   = rem_next;
               num_in   = TB'(rem_next);
               rem_in   = '0;
               div_in   = pp_ff;
               state_in = rkgng_pkg::ST_DIV_QUO;
            end
         end
         rkgng_pkg::ST_DIV_QUO: begin
            num_in = num_next;
            rem_in = rem_next;
            cnt_in = cnt_ff + CB'(1);
            if (div_done) begin
               rem_in   = '0;
               div_in   = NB'(r_ff);
               state_in = rkgng_pkg::ST_DIV_DIG;
            end
         end
         rkgng_pkg::ST_DIV_DIG: begin
            num_in = num_next;
            rem_in = rem_next;
            cnt_in = cnt_ff + CB'(1);
            if (div_done) begin
               digit_in = rem_next[MB-1:0];
               state_in = rkgng_pkg::ST_MUL_REST;
            end
         end
         rkgng_pkg::ST_MUL_REST: begin
            // block index with the chosen digit cleared
            rest_in  = blk_ff - mul_p[NB-1:0];
            state_in = rkgng_pkg::ST_MUL_OFS;
         end
         rkgng_pkg::ST_MUL_OFS: begin
            id_in     = IB'(rest_ff) + mul_p[IB-1:0];
            member_in = '0;
            state_in  = rkgng_pkg::ST_EMIT;
         end
         rkgng_pkg::ST_EMIT: begin
            rsp_valid        = 1'b1;
            rsp_neighbor_id  = id_ff;
            rsp_member_index = member_ff;
            rsp_last_member  = last_now;
            id_in     = id_ff + IB'(pp_ff);
            member_in = member_ff + MB'(1);
            if (last_now) begin
               state_in = rkgng_pkg::ST_IDLE;
            end
         end
         rkgng_pkg::ST_ERROR: begin
            rsp_valid       = 1'b1;
            rsp_last_member = 1'b1;
            rsp_bad_request = 1'b1;
            state_in        = rkgng_pkg::ST_IDLE;
         end
         default: begin
            state_in = rkgng_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rkgng_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_levels_ff <= LB'(1);
         total_ff      <= NB'(1);
         for (int i = 0; i < MAX_LEVELS; i++) begin
            radix_ff[i] <= RB'(1);
         end
      end else begin
         num_levels_ff <= num_levels_in;
         total_ff      <= total_in;
         for (int i = 0; i < MAX_LEVELS; i++) begin
            radix_ff[i] <= radix_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      base_ff      <= base_in;
      lvl_ff       <= lvl_in;
      dir_ff       <= dir_in;
      idx_ff       <= idx_in;
      acc_ff       <= acc_in;
      ovf_ff       <= ovf_in;
      radix_bad_ff <= radix_bad_in;
      pp_ff        <= pp_in;
      r_ff         <= r_in;
      num_ff       <= num_in;
      rem_ff       <= rem_in;
      div_ff       <= div_in;
      cnt_ff       <= cnt_in;
      blk_ff       <= blk_in;
      digit_ff     <= digit_in;
      rest_ff      <= rest_in;
      id_ff        <= id_in;
      member_ff    <= member_in;
   end

   `RKG_ASSERT_NEXT(a_start_sets_busy, start && !busy, busy)
   `RKG_ASSERT_NEXT(a_last_frees_block, rsp_valid && rsp_last_member, !busy)
   `RKG_ASSERT_NEXT(a_members_back_to_back, rsp_valid && !rsp_last_member, rsp_valid)
   `RKG_ASSERT_NEXT(a_member_counts_up, rsp_valid && !rsp_last_member,
                    rsp_member_index == $past(rsp_member_index) + 6'd1)
   `RKG_ASSERT_NOW(a_error_is_single, rsp_valid && rsp_bad_request,
                   rsp_last_member && rsp_neighbor_id == '0)

endmodule
